/* hw/rtl/elds_pkg.sv */
`timescale 1ns / 1ps

package elds_pkg;

  localparam int unsigned WHEELS     = 4;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned SUM_W      = MAG_W + 2;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned TRIM_W     = 11;
  localparam int unsigned TRIM_FRAC  = 10;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned LIM_W      = 31;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned FRAC_SHIFT = 8;
  localparam int unsigned TIMING_W   = 3 * MS_W;
  localparam int unsigned TRIMS_W    = WHEELS * TRIM_W;
  localparam int unsigned TRAVEL_W   = 32;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned OUTCOME_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [DUTY_W-1:0]   CRAWL_DUTY_RST = 8'd70;
  localparam logic [DUTY_W-1:0]   BOOST_DUTY_RST = 8'd140;
  localparam logic [TIMING_W-1:0] TIMING_RST     = {16'd30000, 16'd5000, 16'd220};
  localparam logic [LIM_W-1:0]    TARGET_RST     = 31'd11840;
  localparam logic [LIM_W-1:0]    FS_MIN_RST     = 31'd200;
  localparam logic [LIM_W-1:0]    SLIP_CHECK_RST = 31'd7000;
  localparam logic [FRAC_W-1:0]   SLIP_FRAC_RST  = 16'd141;
  localparam logic [TRIMS_W-1:0]  TRIMS_RST      = {11'd1024, 11'd936, 11'd859, 11'd840};

  // a zero minimum counts as a spread of exactly one
  localparam logic [FRAC_W-1:0]   FRAC_ONE       = 16'd256;
  localparam logic [DUTY_W-1:0]   DUTY_MAX       = 8'd255;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // right wheels take B going forward, left wheels going backward
  localparam logic [WHEELS-1:0] PIN_B_FWD = 4'b0011;
  localparam logic [WHEELS-1:0] PIN_B_REV = 4'b1100;

  localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_KICK = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_RUN  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_DONE = 2'd3;

  localparam logic [OUTCOME_W-1:0] OUT_REACHED  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FAILSAFE = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_TIMEOUT  = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_SLIP     = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CRAWL_DUTY  = 3'd0,
    REG_BOOST_DUTY  = 3'd1,
    REG_TIMING      = 3'd2,
    REG_TARGET      = 3'd3,
    REG_FS_MIN      = 3'd4,
    REG_SLIP_CHECK  = 3'd5,
    REG_SLIP_FRAC   = 3'd6,
    REG_TRIMS       = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    LEG_IDLE = 4'b0001,
    LEG_KICK = 4'b0010,
    LEG_RUN  = 4'b0100,
    LEG_DONE = 4'b1000
  } leg_phase_e;

  function automatic logic [PHASE_W-1:0] phase_code(leg_phase_e p);
    logic [PHASE_W-1:0] c;
    case (p)
      LEG_IDLE: c = PHASE_IDLE;
      LEG_KICK: c = PHASE_KICK;
      LEG_RUN:  c = PHASE_RUN;
      LEG_DONE: c = PHASE_DONE;
      default:  c = PHASE_IDLE;
    endcase
    return c;
  endfunction

  // (duty * trim + half) >> 10, saturated
  function automatic logic [DUTY_W-1:0] trim_duty(logic [DUTY_W-1:0] duty,
                                                  logic [TRIM_W-1:0] trim);
    logic [DUTY_W+TRIM_W-1:0]           prod;
    logic [DUTY_W+TRIM_W:0]             rnd;
    logic [DUTY_W+TRIM_W-TRIM_FRAC:0]   scaled;
    logic [DUTY_W-1:0]                  res;
    prod   = duty * trim;
    rnd    = {1'b0, prod} + (DUTY_W+TRIM_W+1)'(1 << (TRIM_FRAC - 1));
    scaled = rnd[DUTY_W+TRIM_W:TRIM_FRAC];
    if (scaled > {{(TRIM_W-TRIM_FRAC+1){1'b0}}, DUTY_MAX}) begin
      res = DUTY_MAX;
    end else begin
      res = scaled[DUTY_W-1:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/elds_if.sv */
`timescale 1ns / 1ps

interface elds_in_if import elds_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic                    forward;
  logic signed [CNT_W-1:0] wheel0_count;
  logic signed [CNT_W-1:0] wheel1_count;
  logic signed [CNT_W-1:0] wheel2_count;
  logic signed [CNT_W-1:0] wheel3_count;

  modport source (output valid, opcode, forward, wheel0_count, wheel1_count,
                  wheel2_count, wheel3_count, input ready);
  modport sink   (input valid, opcode, forward, wheel0_count, wheel1_count,
                  wheel2_count, wheel3_count, output ready);
endinterface

interface elds_out_if import elds_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DUTY_W-1:0]    wheel0_duty;
  logic [DUTY_W-1:0]    wheel1_duty;
  logic [DUTY_W-1:0]    wheel2_duty;
  logic [DUTY_W-1:0]    wheel3_duty;
  logic [WHEELS-1:0]    pin_b_mask;
  logic [PHASE_W-1:0]   phase;
  logic [OUTCOME_W-1:0] outcome;
  logic [TRAVEL_W-1:0]  travelled;

  modport source (output valid, wheel0_duty, wheel1_duty, wheel2_duty, wheel3_duty,
                  pin_b_mask, phase, outcome, travelled, input ready);
  modport sink   (input valid, wheel0_duty, wheel1_duty, wheel2_duty, wheel3_duty,
                  pin_b_mask, phase, outcome, travelled, output ready);
endinterface

interface elds_cfg_if import elds_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/encoder_leg_drive_supervisor.sv */
`timescale 1ns / 1ps
// Channel  Dir  Beat
// item_i   in   opcode, forward, wheel0..3_count
// result_o out  wheel0..3_duty, pin_b_mask, phase, outcome, travelled
// cfg_i    in   index, data (always ready)
//
// One item a cycle while the result is not stalled; a taken beat passes through the
// input register, then one pass of travel, checks and duty trim into the
// result register. Reset is asynchronous, active low, and loads the default
// registers with the leg idle. A stalled result holds; the input register
// still takes one further beat behind it.

module encoder_leg_drive_supervisor import elds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  elds_in_if.sink    item_i,
  elds_out_if.source result_o,
  elds_cfg_if.sink   cfg_i
);

  // configuration
  logic [DUTY_W-1:0]   crawl_duty_q, boost_duty_q;
  logic [TIMING_W-1:0] timing_q;
  logic [LIM_W-1:0]    target_q, fs_min_q, slip_check_q;
  logic [FRAC_W-1:0]   slip_frac_q;
  logic [TRIMS_W-1:0]  trims_q;

  // input register
  logic                    in_valid_q;
  logic                    in_op_q, in_fwd_q;
  logic signed [CNT_W-1:0] in_cnt_q [WHEELS];

  // leg state
  leg_phase_e              phase_q, phase_d;
  logic                    dir_q, dir_d;
  logic signed [CNT_W-1:0] start_q [WHEELS];
  logic signed [CNT_W-1:0] start_d [WHEELS];
  logic [MS_W-1:0]         elapsed_q, elapsed_d;
  logic [OUTCOME_W-1:0]    outcome_q, outcome_d;

  // result register
  logic                 out_valid_q;
  logic [DUTY_W-1:0]    out_duty_q [WHEELS];
  logic [DUTY_W-1:0]    out_duty_d [WHEELS];
  logic [WHEELS-1:0]    out_mask_q, out_mask_d;
  logic [PHASE_W-1:0]   out_phase_q;
  logic [OUTCOME_W-1:0] out_outcome_q, out_outcome_d;
  logic [TRAVEL_W-1:0]  out_travel_q;

  logic                 adv, take;
  logic                 is_start;
  logic [MAG_W-1:0]     mag [WHEELS];
  logic [SUM_W-1:0]     sum;
  logic [MAG_W-1:0]     lo, hi;
  logic [TRAVEL_W-1:0]  got;
  logic                 slip;
  logic [MS_W-1:0]      el_inc;
  logic [MS_W-1:0]      kick_ms, fs_ms, hard_ms;

  assign adv  = in_valid_q && (!out_valid_q || result_o.ready);
  assign take = item_i.valid && item_i.ready;
  assign item_i.ready = !in_valid_q || adv;
  assign cfg_i.ready  = 1'b1;

  assign kick_ms = timing_q[MS_W-1:0];
  assign fs_ms   = timing_q[2*MS_W-1:MS_W];
  assign hard_ms = timing_q[3*MS_W-1:2*MS_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crawl_duty_q <= CRAWL_DUTY_RST;
      boost_duty_q <= BOOST_DUTY_RST;
      timing_q     <= TIMING_RST;
      target_q     <= TARGET_RST;
      fs_min_q     <= FS_MIN_RST;
      slip_check_q <= SLIP_CHECK_RST;
      slip_frac_q  <= SLIP_FRAC_RST;
      trims_q      <= TRIMS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_CRAWL_DUTY: crawl_duty_q <= cfg_i.data[DUTY_W-1:0];
        REG_BOOST_DUTY: boost_duty_q <= cfg_i.data[DUTY_W-1:0];
        REG_TIMING:     timing_q     <= cfg_i.data[TIMING_W-1:0];
        REG_TARGET:     target_q     <= cfg_i.data[LIM_W-1:0];
        REG_FS_MIN:     fs_min_q     <= cfg_i.data[LIM_W-1:0];
        REG_SLIP_CHECK: slip_check_q <= cfg_i.data[LIM_W-1:0];
        REG_SLIP_FRAC:  slip_frac_q  <= cfg_i.data[FRAC_W-1:0];
        REG_TRIMS:      trims_q      <= cfg_i.data[TRIMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_op_q     <= item_i.opcode;
      in_fwd_q    <= item_i.forward;
      in_cnt_q[0] <= item_i.wheel0_count;
      in_cnt_q[1] <= item_i.wheel1_count;
      in_cnt_q[2] <= item_i.wheel2_count;
      in_cnt_q[3] <= item_i.wheel3_count;
    end
  end

  always_comb begin
    logic signed [CNT_W:0]   diff;
    logic signed [CNT_W-1:0] ref_cnt;
    logic [MAG_W-1:0]        spread;
    logic [MAG_W+FRAC_SHIFT-1:0] lhs;
    logic [MAG_W+FRAC_W-1:0]     rhs;
    is_start = (in_op_q == OP_START);
    sum = '0;
    lo  = '0;
    hi  = '0;
    for (int w = 0; w < WHEELS; w++) begin
      ref_cnt = is_start ? in_cnt_q[w] : start_q[w];
      diff    = {in_cnt_q[w][CNT_W-1], in_cnt_q[w]} - {ref_cnt[CNT_W-1], ref_cnt};
      mag[w]  = diff[CNT_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
      sum     = sum + {2'b00, mag[w]};
      if (w == 0 || mag[w] < lo) begin
        lo = mag[w];
      end
      if (mag[w] > hi) begin
        hi = mag[w];
      end
    end
    got    = sum[SUM_W-1:2];
    spread = hi - lo;
    lhs    = {spread, {FRAC_SHIFT{1'b0}}};
    rhs    = slip_frac_q * lo;
    if (lo == '0) begin
      slip = slip_frac_q < FRAC_ONE;
    end else begin
      slip = {{(FRAC_W-FRAC_SHIFT){1'b0}}, lhs} > rhs;
    end
    el_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  end

  always_comb begin
    leg_phase_e ph;
    ph        = phase_q;
    phase_d   = phase_q;
    dir_d     = dir_q;
    elapsed_d = elapsed_q;
    outcome_d = outcome_q;
    start_d   = start_q;
    if (is_start) begin
      start_d   = in_cnt_q;
      dir_d     = in_fwd_q;
      elapsed_d = '0;
      phase_d   = LEG_KICK;
    end else if (phase_q == LEG_KICK || phase_q == LEG_RUN) begin
      elapsed_d = el_inc;
      if (ph == LEG_KICK && el_inc >= kick_ms) begin
        ph = LEG_RUN;
      end
      if (ph == LEG_RUN) begin
        // checks in priority order; the first that holds ends the leg
        if (got >= {1'b0, target_q}) begin
          outcome_d = OUT_REACHED;
          ph = LEG_DONE;
        end else if (el_inc > fs_ms && got < {1'b0, fs_min_q}) begin
          outcome_d = OUT_FAILSAFE;
          ph = LEG_DONE;
        end else if (got > {1'b0, slip_check_q} && slip) begin
          outcome_d = OUT_SLIP;
          ph = LEG_DONE;
        end else if (el_inc > hard_ms) begin
          outcome_d = OUT_TIMEOUT;
          ph = LEG_DONE;
        end
      end
      phase_d = ph;
    end

    for (int w = 0; w < WHEELS; w++) begin
      case (phase_d)
        LEG_KICK: out_duty_d[w] = trim_duty(boost_duty_q, trims_q[w*TRIM_W +: TRIM_W]);
        LEG_RUN:  out_duty_d[w] = trim_duty(crawl_duty_q, trims_q[w*TRIM_W +: TRIM_W]);
        default:  out_duty_d[w] = '0;
      endcase
    end
    if (phase_d == LEG_KICK || phase_d == LEG_RUN) begin
      out_mask_d = dir_d ? PIN_B_FWD : PIN_B_REV;
    end else begin
      out_mask_d = '0;
    end
    out_outcome_d = (phase_d == LEG_DONE) ? outcome_d : OUT_REACHED;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= LEG_IDLE;
      dir_q       <= 1'b0;
      elapsed_q   <= '0;
      outcome_q   <= OUT_REACHED;
      for (int w = 0; w < WHEELS; w++) begin
        start_q[w] <= '0;
      end
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        dir_q       <= dir_d;
        elapsed_q   <= elapsed_d;
        outcome_q   <= outcome_d;
        start_q     <= start_d;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_duty_q    <= out_duty_d;
      out_mask_q    <= out_mask_d;
      out_phase_q   <= phase_code(phase_d);
      out_outcome_q <= out_outcome_d;
      out_travel_q  <= got;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.wheel0_duty = out_duty_q[0];
  assign result_o.wheel1_duty = out_duty_q[1];
  assign result_o.wheel2_duty = out_duty_q[2];
  assign result_o.wheel3_duty = out_duty_q[3];
  assign result_o.pin_b_mask  = out_mask_q;
  assign result_o.phase       = out_phase_q;
  assign result_o.outcome     = out_outcome_q;
  assign result_o.travelled   = out_travel_q;

`ifndef NO_ASSERTIONS
  a_stopped_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_phase_q == PHASE_IDLE || out_phase_q == PHASE_DONE)
    |-> out_mask_q == '0 && out_duty_q[0] == '0 && out_duty_q[3] == '0)
    else $error("duty driven while idle or finished");

  a_outcome_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_phase_q != PHASE_DONE |-> out_outcome_q == OUT_REACHED)
    else $error("outcome reported outside finished phase");

  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_op_q) && $stable(in_cnt_q[0]))
    else $error("stalled input register lost or overwritten");

  a_start_zero_travel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_op_q == OP_START
    |=> out_travel_q == '0 && out_phase_q == PHASE_KICK && elapsed_q == '0)
    else $error("start beat did not restart the leg");
`endif

endmodule

/* test/tb_encoder_leg_drive_supervisor.sv */
`timescale 1ns / 1ps

module tb_encoder_leg_drive_supervisor;
  import elds_pkg::*;

  localparam logic signed [CNT_W-1:0] CNT_MAX = 32'sh7fff_ffff;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 32'sh8000_0000;
  localparam logic [LIM_W-1:0]        LIM_TOP = '1;
  localparam logic [TRIMS_W-1:0]      TRIMS_UNITY = {WHEELS{11'd1024}};
  localparam int unsigned             ITEMS_WANTED = 1680;

  typedef enum int unsigned {SINK_OPEN, SINK_COIN, SINK_QUARTER, SINK_MOSTLY} sink_mode_e;
  typedef enum int unsigned {STYLE_REACH, STYLE_STALL, STYLE_SLIP, STYLE_NOISE} leg_style_e;

  typedef struct {
    logic                    op;
    logic                    fwd;
    logic signed [CNT_W-1:0] cnt [WHEELS];
  } leg_item_t;

  typedef struct {
    logic [DUTY_W-1:0]    duty [WHEELS];
    logic [WHEELS-1:0]    pin_b;
    logic [PHASE_W-1:0]   phase;
    logic [OUTCOME_W-1:0] outcome;
    logic [TRAVEL_W-1:0]  travelled;
  } leg_drive_t;

  class leg_tracker;
    logic [DUTY_W-1:0]       crawl_duty;
    logic [DUTY_W-1:0]       boost_duty;
    logic [TIMING_W-1:0]     timing;
    logic [LIM_W-1:0]        target;
    logic [LIM_W-1:0]        fs_min;
    logic [LIM_W-1:0]        slip_chk;
    logic [FRAC_W-1:0]       slip_frac;
    logic [TRIMS_W-1:0]      trims;
    logic [PHASE_W-1:0]      leg_ph;
    logic                    dir;
    logic signed [CNT_W-1:0] origin [WHEELS];
    logic [MS_W-1:0]         elapsed;
    logic [OUTCOME_W-1:0]    last_out;
    leg_drive_t              drive_due [$];
    int                      n_checked;
    int                      errors;

    function new();
      crawl_duty = CRAWL_DUTY_RST;
      boost_duty = BOOST_DUTY_RST;
      timing     = TIMING_RST;
      target     = TARGET_RST;
      fs_min     = FS_MIN_RST;
      slip_chk   = SLIP_CHECK_RST;
      slip_frac  = SLIP_FRAC_RST;
      trims      = TRIMS_RST;
      leg_ph     = PHASE_IDLE;
      dir        = 1'b0;
      foreach (origin[i]) origin[i] = '0;
      elapsed    = '0;
      last_out   = OUT_REACHED;
      n_checked  = 0;
      errors     = 0;
    endfunction

    function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (cfg_reg_e'(idx))
        REG_CRAWL_DUTY: crawl_duty = data[DUTY_W-1:0];
        REG_BOOST_DUTY: boost_duty = data[DUTY_W-1:0];
        REG_TIMING:     timing     = data[TIMING_W-1:0];
        REG_TARGET:     target     = data[LIM_W-1:0];
        REG_FS_MIN:     fs_min     = data[LIM_W-1:0];
        REG_SLIP_CHECK: slip_chk   = data[LIM_W-1:0];
        REG_SLIP_FRAC:  slip_frac  = data[FRAC_W-1:0];
        REG_TRIMS:      trims      = data[TRIMS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DUTY_W-1:0] scale_duty(logic [DUTY_W-1:0] d, int w);
      int unsigned t;
      int unsigned s;
      t = 32'(trims[w*TRIM_W +: TRIM_W]);
      s = (32'(d) * t + 32'd512) >> TRIM_FRAC;
      return (s > 32'(DUTY_MAX)) ? DUTY_MAX : DUTY_W'(s);
    endfunction

    function leg_drive_t predict_drive(leg_item_t it);
      leg_drive_t        r;
      longint            diff;
      longint unsigned   m;
      longint unsigned   sum;
      longint unsigned   lo;
      longint unsigned   hi;
      longint unsigned   got;
      logic              slip;
      logic              drive;
      logic [DUTY_W-1:0] duty;
      if (it.op == OP_START) begin
        foreach (origin[i]) origin[i] = it.cnt[i];
        dir     = it.fwd;
        elapsed = '0;
        leg_ph  = PHASE_KICK;
      end
      sum = 0;
      lo  = 0;
      hi  = 0;
      for (int i = 0; i < WHEELS; i++) begin
        diff = longint'(it.cnt[i]) - longint'(origin[i]);
        m    = (diff < 0) ? -diff : diff;
        sum += m;
        if (i == 0 || m < lo) lo = m;
        if (m > hi) hi = m;
      end
      got = sum >> 2;
      if (it.op == OP_TICK && (leg_ph == PHASE_KICK || leg_ph == PHASE_RUN)) begin
        if (elapsed != '1) elapsed++;
        if (leg_ph == PHASE_KICK && elapsed >= timing[MS_W-1:0]) leg_ph = PHASE_RUN;
        if (leg_ph == PHASE_RUN) begin
          // a zero minimum stands for a spread of exactly one
          if (lo == 0) slip = (slip_frac < FRAC_ONE);
          else slip = ((hi - lo) << FRAC_SHIFT) > (64'(slip_frac) * lo);
          if (got >= 64'(target)) begin
            last_out = OUT_REACHED;
            leg_ph   = PHASE_DONE;
          end else if (elapsed > timing[2*MS_W-1:MS_W] && got < 64'(fs_min)) begin
            last_out = OUT_FAILSAFE;
            leg_ph   = PHASE_DONE;
          end else if (got > 64'(slip_chk) && slip) begin
            last_out = OUT_SLIP;
            leg_ph   = PHASE_DONE;
          end else if (elapsed > timing[3*MS_W-1:2*MS_W]) begin
            last_out = OUT_TIMEOUT;
            leg_ph   = PHASE_DONE;
          end
        end
      end
      drive = (leg_ph == PHASE_KICK || leg_ph == PHASE_RUN);
      duty  = (leg_ph == PHASE_KICK) ? boost_duty : crawl_duty;
      for (int i = 0; i < WHEELS; i++) r.duty[i] = drive ? scale_duty(duty, i) : '0;
      r.pin_b     = drive ? (dir ? PIN_B_FWD : PIN_B_REV) : '0;
      r.phase     = leg_ph;
      r.outcome   = (leg_ph == PHASE_DONE) ? last_out : OUT_REACHED;
      r.travelled = got[TRAVEL_W-1:0];
      return r;
    endfunction

    function void take_item(leg_item_t it);
      drive_due.push_back(predict_drive(it));
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        errors++;
      end
    endfunction

    function void check_drive(leg_drive_t seen);
      leg_drive_t want;
      n_checked++;
      if (drive_due.size() == 0) begin
        $error("result beat arrived with nothing expected");
        errors++;
        return;
      end
      want = drive_due.pop_front();
      for (int i = 0; i < WHEELS; i++)
        compare($sformatf("wheel%0d_duty", i), 64'(want.duty[i]), 64'(seen.duty[i]));
      compare("pin_b_mask", 64'(want.pin_b), 64'(seen.pin_b));
      compare("phase", 64'(want.phase), 64'(seen.phase));
      compare("outcome", 64'(want.outcome), 64'(seen.outcome));
      compare("travelled", 64'(want.travelled), 64'(seen.travelled));
    endfunction

    function void report_leftover();
      if (drive_due.size() != 0) begin
        $error("%0d result beats never arrived", drive_due.size());
        errors += drive_due.size();
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  elds_in_if  item_if ();
  elds_out_if result_if ();
  elds_cfg_if cfg_if ();

  encoder_leg_drive_supervisor dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if),
    .result_o(result_if),
    .cfg_i   (cfg_if)
  );

  leg_tracker  board = new();
  int          n_sent = 0;
  int unsigned burst_left = 0;
  bit          steady = 1'b0;
  int unsigned step_size = 1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // output checked before input is noted, so a fresh beat never meets its own result
  always @(posedge clk) begin : watch
    leg_item_t  it;
    leg_drive_t seen;
    if (rst_n === 1'b1) begin
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        seen.duty[0]   = result_if.wheel0_duty;
        seen.duty[1]   = result_if.wheel1_duty;
        seen.duty[2]   = result_if.wheel2_duty;
        seen.duty[3]   = result_if.wheel3_duty;
        seen.pin_b     = result_if.pin_b_mask;
        seen.phase     = result_if.phase;
        seen.outcome   = result_if.outcome;
        seen.travelled = result_if.travelled;
        board.check_drive(seen);
      end
      if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)
        board.note_reg(cfg_if.index, cfg_if.data);
      if (item_if.valid === 1'b1 && item_if.ready === 1'b1) begin
        it.op     = item_if.opcode;
        it.fwd    = item_if.forward;
        it.cnt[0] = item_if.wheel0_count;
        it.cnt[1] = item_if.wheel1_count;
        it.cnt[2] = item_if.wheel2_count;
        it.cnt[3] = item_if.wheel3_count;
        board.take_item(it);
      end
    end
  end

  // receiver back-pressure: switches at random among four patterns
  sink_mode_e  sink_mode = SINK_OPEN;
  int unsigned sink_left = 0;
  int unsigned sink_tick = 0;

  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(32, 400);
    end
    sink_left--;
    sink_tick++;
    case (sink_mode)
      SINK_OPEN:    result_if.ready <= 1'b1;
      SINK_COIN:    result_if.ready <= 1'($urandom);
      SINK_QUARTER: result_if.ready <= (sink_tick % 4 == 0);
      default:      result_if.ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic await_results();
    while (board.n_checked < n_sent) @(posedge clk);
  endtask

  // sender bursts; now and then it holds back until every result is in
  task automatic pace();
    int unsigned gap;
    bit          hold;
    gap  = 0;
    hold = !steady && ($urandom_range(0, 99) == 0);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if (!steady) gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      steady     = ($urandom_range(0, 5) == 0);
    end
    if (gap != 0 || hold) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (hold) await_results();
    end
  endtask

  task automatic send_item(input logic op, input logic fwd,
                           input logic signed [CNT_W-1:0] c0, c1, c2, c3);
    item_if.valid        <= 1'b1;
    item_if.opcode       <= op;
    item_if.forward      <= fwd;
    item_if.wheel0_count <= c0;
    item_if.wheel1_count <= c1;
    item_if.wheel2_count <= c2;
    item_if.wheel3_count <= c3;
    @(posedge clk);
    while (item_if.ready !== 1'b1) @(posedge clk);
    n_sent++;
    pace();
  endtask

  task automatic settle();
    item_if.valid <= 1'b0;
    await_results();
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
  endtask

  // registers only change with the pipeline empty
  task automatic program_leg(input logic [DUTY_W-1:0] base, kick,
                             input logic [MS_W-1:0] kick_ms, fs_ms, hard_ms,
                             input logic [LIM_W-1:0] target, fs_min, slip_chk,
                             input logic [FRAC_W-1:0] frac,
                             input logic [TRIMS_W-1:0] trims);
    settle();
    write_reg(REG_CRAWL_DUTY, CFG_DATA_W'(base));
    write_reg(REG_BOOST_DUTY, CFG_DATA_W'(kick));
    write_reg(REG_TIMING, {hard_ms, fs_ms, kick_ms});
    write_reg(REG_TARGET, CFG_DATA_W'(target));
    write_reg(REG_FS_MIN, CFG_DATA_W'(fs_min));
    write_reg(REG_SLIP_CHECK, CFG_DATA_W'(slip_chk));
    write_reg(REG_SLIP_FRAC, CFG_DATA_W'(frac));
    write_reg(REG_TRIMS, CFG_DATA_W'(trims));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [LIM_W-1:0] pick_lim(input int unsigned typ);
    logic [LIM_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      default: v = LIM_W'(typ);
    endcase
    return v;
  endfunction

  function automatic logic [DUTY_W-1:0] pick_duty();
    logic [DUTY_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = DUTY_MAX;
      default: v = DUTY_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic random_setting();
    logic [MS_W-1:0]    k;
    logic [MS_W-1:0]    f;
    logic [MS_W-1:0]    h;
    logic [FRAC_W-1:0]  frac;
    logic [TRIMS_W-1:0] trims;
    step_size = $urandom_range(1, 300);
    if ($urandom_range(0, 9) == 0) begin
      k = MS_W'($urandom);
      f = MS_W'($urandom);
      h = MS_W'($urandom);
    end else begin
      k = MS_W'($urandom_range(0, 6));
      f = MS_W'($urandom_range(0, 30));
      h = MS_W'($urandom_range(0, 60));
    end
    case ($urandom_range(0, 9))
      0:       frac = '0;
      1:       frac = '1;
      2:       frac = FRAC_ONE - 16'd1;
      3:       frac = FRAC_ONE;
      default: frac = FRAC_W'($urandom_range(16, 300));
    endcase
    case ($urandom_range(0, 7))
      0:       trims = '0;
      1:       trims = '1;
      2:       trims = TRIMS_W'({$urandom, $urandom});
      default: begin
        for (int i = 0; i < WHEELS; i++)
          trims[i*TRIM_W +: TRIM_W] = TRIM_W'($urandom_range(600, 1500));
      end
    endcase
    program_leg(pick_duty(), pick_duty(), k, f, h,
                pick_lim(step_size * $urandom_range(2, 40)),
                pick_lim(step_size * $urandom_range(0, 6)),
                pick_lim(step_size * $urandom_range(0, 30)),
                frac, trims);
  endtask

  // one start beat, then ticks at per-wheel rates, or random beats when noisy
  task automatic run_leg(input leg_style_e style);
    logic signed [CNT_W-1:0] pos [WHEELS];
    int                      rate [WHEELS];
    int unsigned             lag;
    int unsigned             n_ticks;
    logic                    fwd;
    fwd     = 1'($urandom);
    lag     = $urandom_range(0, 3);
    n_ticks = $urandom_range(1, 50);
    for (int i = 0; i < WHEELS; i++) begin
      if ($urandom_range(0, 7) == 0) pos[i] = CNT_W'($urandom);
      else pos[i] = CNT_W'($urandom_range(0, 2000)) - 32'sd1000;
      case (style)
        STYLE_REACH: rate[i] = int'(step_size + $urandom_range(0, step_size / 8));
        STYLE_STALL: rate[i] = int'($urandom_range(0, 1));
        STYLE_SLIP:  rate[i] = (i == lag) ? int'(step_size / $urandom_range(2, 5))
                                          : int'(step_size);
        default:     rate[i] = 0;
      endcase
      // a wheel turning the wrong way still adds travel
      if ($urandom_range(0, 3) == 0) rate[i] = -rate[i];
    end
    send_item(OP_START, fwd, pos[0], pos[1], pos[2], pos[3]);
    repeat (n_ticks) begin
      if (style == STYLE_NOISE) begin
        for (int i = 0; i < WHEELS; i++) pos[i] = CNT_W'($urandom);
        send_item(($urandom_range(0, 7) == 0) ? OP_START : OP_TICK, 1'($urandom),
                  pos[0], pos[1], pos[2], pos[3]);
      end else begin
        for (int i = 0; i < WHEELS; i++) pos[i] = pos[i] + rate[i];
        send_item(OP_TICK, 1'($urandom), pos[0], pos[1], pos[2], pos[3]);
      end
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    item_if.valid        <= 1'b0;
    item_if.opcode       <= OP_TICK;
    item_if.forward      <= 1'b0;
    item_if.wheel0_count <= '0;
    item_if.wheel1_count <= '0;
    item_if.wheel2_count <= '0;
    item_if.wheel3_count <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= REG_CRAWL_DUTY;
    cfg_if.data          <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle ticks measure from the zeroed start counts
    send_item(OP_TICK, 1'b0, CNT_MAX, CNT_MIN, -32'sd1, 32'sd0);
    send_item(OP_TICK, 1'b1, CNT_MIN, CNT_MIN, CNT_MIN, CNT_MIN);
    // widest possible travel, then a restart mid-leg in reverse
    send_item(OP_START, 1'b1, CNT_MIN, CNT_MIN, CNT_MIN, CNT_MIN);
    send_item(OP_TICK, 1'b0, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX);
    send_item(OP_START, 1'b0, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX);
    send_item(OP_TICK, 1'b1, CNT_MIN, CNT_MIN, CNT_MIN, CNT_MIN);

    // zero kick time: first tick already checks; then a tick once finished
    program_leg(8'd70, 8'd140, 16'd0, 16'd5000, 16'd30000, '0, 31'd200, 31'd7000,
                16'd141, TRIMS_RST);
    send_item(OP_START, 1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_item(OP_TICK, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_item(OP_TICK, 1'b0, 32'sd5, 32'sd5, 32'sd5, 32'sd5);

    // saturated duties, then the failsafe
    program_leg(DUTY_MAX, DUTY_MAX, 16'd1, 16'd1, 16'd1000, LIM_TOP, 31'd1, LIM_TOP,
                16'd141, '1);
    send_item(OP_START, 1'b0, 32'sd100, -32'sd100, 32'sd7, 32'sd0);
    send_item(OP_TICK, 1'b0, 32'sd100, -32'sd100, 32'sd7, 32'sd0);
    send_item(OP_TICK, 1'b0, 32'sd100, -32'sd100, 32'sd7, 32'sd0);
    send_item(OP_TICK, 1'b1, 32'sd100, -32'sd100, 32'sd7, 32'sd0);

    // zero minimum wheel: slip just below one in Q8, none at exactly one
    program_leg('0, '0, 16'd0, 16'd1000, 16'd0, LIM_TOP, '0, '0, FRAC_ONE - 16'd1, '0);
    send_item(OP_START, 1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_item(OP_TICK, 1'b1, 32'sd100, 32'sd100, 32'sd100, 32'sd0);
    program_leg('0, '0, 16'd0, 16'd1000, 16'd0, LIM_TOP, '0, '0, FRAC_ONE, '0);
    send_item(OP_START, 1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_item(OP_TICK, 1'b1, 32'sd100, 32'sd100, 32'sd100, 32'sd0);

    // spread just above and exactly at the slip fraction, non-zero minimum
    program_leg(8'd1, 8'd200, 16'd0, 16'd1000, 16'd1000, 31'd100000, '0, 31'd10,
                16'd128, TRIMS_UNITY);
    send_item(OP_START, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_item(OP_TICK, 1'b0, -32'sd40, 32'sd40, -32'sd40, 32'sd61);
    send_item(OP_START, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_item(OP_TICK, 1'b0, -32'sd40, 32'sd40, -32'sd40, 32'sd60);

    while (n_sent < ITEMS_WANTED) begin
      random_setting();
      repeat ($urandom_range(2, 8)) begin
        case ($urandom_range(0, 9))
          6:       run_leg(STYLE_STALL);
          7, 8:    run_leg(STYLE_SLIP);
          9:       run_leg(STYLE_NOISE);
          default: run_leg(STYLE_REACH);
        endcase
      end
    end

    settle();
    repeat (8) @(posedge clk);
    board.report_leftover();
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $error("run timed out");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
